// ===== hdl/lfd_pkg.sv =====
package lfd_pkg;

  localparam int unsigned MAX_POINTS_DEF = 1024;

  localparam int unsigned SUM_X_W  = 27;
  localparam int unsigned SUM_XX_W = 41;
  localparam int unsigned SUM_XY_W = 42;
  localparam int unsigned SPLIT_W  = 21;
  localparam int unsigned MUL_A_W  = 33;
  localparam int unsigned MUL_B_W  = 28;
  localparam int unsigned PROD_W   = MUL_A_W + MUL_B_W;
  localparam int unsigned FIT_W    = 53;
  localparam int unsigned DIV_W    = 70;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_W + 1);

  localparam logic [1:0] OPC_ADD   = 2'd0;
  localparam logic [1:0] OPC_QUERY = 2'd1;
  localparam logic [1:0] OPC_CLEAR = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_ADD,
    OP_CLEAR,
    OP_CAPTURE,
    OP_M_NXX_LO,
    OP_M_NXX_HI,
    OP_M_SXSX,
    OP_M_NXY_LO,
    OP_M_NXY_HI,
    OP_M_SXSY,
    OP_NUM_END,
    OP_SDIV_INIT,
    OP_DIV_STEP,
    OP_SLOPE_FIN,
    OP_M_ASX,
    OP_BDIV_INIT,
    OP_B_FIN,
    OP_M_AX,
    OP_DEV,
    OP_DEGEN
  } dp_op_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DEN_LO,
    S_DEN_HI,
    S_DEN_SQ,
    S_NUM_LO,
    S_NUM_HI,
    S_NUM_SQ,
    S_NUM_END,
    S_CHECK,
    S_SDIV,
    S_SFIN,
    S_BMUL,
    S_BINIT,
    S_BDIV,
    S_BFIN,
    S_DMUL,
    S_DEV
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic degen;
  } dp_stat_t;

endpackage

// ===== hdl/lfd_datapath.sv =====
module lfd_datapath #(
  parameter int unsigned MaxPoints = lfd_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lfd_pkg::dp_cmd_t   cmd_i,
  output lfd_pkg::dp_stat_t  stat_o,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  output logic               done_o,
  output logic signed [31:0] slope_o,
  output logic signed [31:0] intercept_o,
  output logic        [30:0] deviation_o,
  output logic               degenerate_o
);
  import lfd_pkg::*;

  localparam int unsigned CntW = $clog2(MaxPoints + 1);

  // running sums
  logic [CntW-1:0]            cnt_q;
  logic signed [SUM_X_W-1:0]  sx_q, sy_q;
  logic [SUM_XX_W-1:0]        sxx_q;
  logic signed [SUM_XY_W-1:0] sxy_q;
  logic                       done_q;
  logic [DIV_CNT_W-1:0]       div_cnt_q;

  logic signed [15:0]         qx_q, qy_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [63:0]         acc_q;
  logic signed [FIT_W-1:0]    den_q, num_q;
  logic [DIV_W-1:0]           dvd_q, quo_q;
  logic [FIT_W-1:0]           rem_q, dsr_q;
  logic                       neg_q, sat_q;
  logic signed [31:0]         aq_q, bq_q;
  logic signed [31:0]         slope_q, icpt_q;
  logic [30:0]                dev_q;
  logic                       degen_q;

  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   prod_d;
  logic [MUL_B_W-1:0]         n_ext;
  logic signed [31:0]         xx, xy;
  logic [FIT_W-1:0]           num_mag;
  logic                       slope_sat;
  logic [32:0]                f_rnd;
  logic signed [31:0]         aq_d, bq_d;
  logic signed [63:0]         numb, t_val;
  logic [63:0]                numb_mag, b_dvd, t_mag, t_rnd;
  logic [30:0]                dev_d;
  logic [FIT_W-1:0]           rem_sh;
  logic                       q_bit;

  assign n_ext = MUL_B_W'(cnt_q);
  assign xx    = 32'(x_value_i) * 32'(x_value_i);
  assign xy    = 32'(x_value_i) * 32'(y_value_i);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_M_NXX_LO: begin
        mul_a = MUL_A_W'(sxx_q[SPLIT_W-1:0]);
        mul_b = n_ext;
      end
      OP_M_NXX_HI: begin
        mul_a = MUL_A_W'(sxx_q[SUM_XX_W-1:SPLIT_W]);
        mul_b = n_ext;
      end
      OP_M_SXSX: begin
        mul_a = MUL_A_W'(sx_q);
        mul_b = MUL_B_W'(sx_q);
      end
      OP_M_NXY_LO: begin
        mul_a = MUL_A_W'(sxy_q[SPLIT_W-1:0]);
        mul_b = n_ext;
      end
      OP_M_NXY_HI: begin
        mul_a = MUL_A_W'(signed'(sxy_q[SUM_XY_W-1:SPLIT_W]));
        mul_b = n_ext;
      end
      OP_M_SXSY: begin
        mul_a = MUL_A_W'(sx_q);
        mul_b = MUL_B_W'(sy_q);
      end
      OP_M_ASX: begin
        mul_a = MUL_A_W'(aq_q);
        mul_b = MUL_B_W'(sx_q);
      end
      OP_M_AX: begin
        mul_a = MUL_A_W'(aq_q);
        mul_b = MUL_B_W'(qx_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'(mul_b);

  // slope: saturate when the integer part reaches 2^15
  assign num_mag   = num_q[FIT_W-1] ? FIT_W'(-num_q) : FIT_W'(num_q);
  assign slope_sat = {15'b0, num_mag} >= {den_q, 15'b0};
  assign f_rnd     = (33'(quo_q[31:0]) + 33'd1) >> 1;

  always_comb begin
    if (sat_q) begin
      aq_d = neg_q ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (neg_q) begin
      aq_d = 32'(-f_rnd);
    end else if (f_rnd[32] || f_rnd[31]) begin
      aq_d = 32'sh7FFF_FFFF;
    end else begin
      aq_d = 32'(f_rnd);
    end
  end

  // intercept: round half away from zero by adding half the divisor
  assign numb     = (64'(sy_q) <<< 16) - 64'(prod_q);
  assign numb_mag = numb[63] ? 64'(-numb) : 64'(numb);
  assign b_dvd    = numb_mag + (64'(cnt_q) << 7);

  always_comb begin
    if (neg_q) begin
      if ((|quo_q[DIV_W-1:32]) || (quo_q[31] && (|quo_q[30:0]))) begin
        bq_d = 32'sh8000_0000;
      end else begin
        bq_d = 32'(-quo_q[31:0]);
      end
    end else if (|quo_q[DIV_W-1:31]) begin
      bq_d = 32'sh7FFF_FFFF;
    end else begin
      bq_d = 32'(quo_q[31:0]);
    end
  end

  assign t_val = 64'(prod_q) + ((64'(bq_q) - (64'(qy_q) <<< 8)) <<< 8);
  assign t_mag = t_val[63] ? 64'(-t_val) : 64'(t_val);
  assign t_rnd = (t_mag + 64'd128) >> 8;
  assign dev_d = (|t_rnd[63:31]) ? 31'h7FFF_FFFF : t_rnd[30:0];

  assign rem_sh = {rem_q[FIT_W-2:0], dvd_q[DIV_W-1]};
  assign q_bit  = rem_sh >= dsr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      sx_q      <= '0;
      sy_q      <= '0;
      sxx_q     <= '0;
      sxy_q     <= '0;
      done_q    <= 1'b0;
      div_cnt_q <= '0;
    end else begin
      done_q <= (cmd_i.op == OP_DEV) || (cmd_i.op == OP_DEGEN);
      case (cmd_i.op)
        OP_ADD: begin
          if (cnt_q < CntW'(MaxPoints)) begin
            cnt_q <= cnt_q + CntW'(1);
            sx_q  <= sx_q + SUM_X_W'(x_value_i);
            sy_q  <= sy_q + SUM_X_W'(y_value_i);
            sxx_q <= sxx_q + SUM_XX_W'(xx);
            sxy_q <= sxy_q + SUM_XY_W'(xy);
          end
        end
        OP_CLEAR: begin
          cnt_q <= '0;
          sx_q  <= '0;
          sy_q  <= '0;
          sxx_q <= '0;
          sxy_q <= '0;
        end
        OP_SDIV_INIT, OP_BDIV_INIT: div_cnt_q <= DIV_CNT_W'(DIV_W);
        OP_DIV_STEP: begin
          if (div_cnt_q != '0) div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    case (cmd_i.op)
      OP_CAPTURE: begin
        qx_q <= x_value_i;
        qy_q <= y_value_i;
      end
      OP_M_NXX_HI, OP_M_NXY_HI: acc_q <= 64'(prod_q);
      OP_M_SXSX, OP_M_SXSY: acc_q <= acc_q + (64'(prod_q) <<< SPLIT_W);
      OP_M_NXY_LO: den_q <= FIT_W'(acc_q - 64'(prod_q));
      OP_NUM_END: num_q <= FIT_W'(acc_q - 64'(prod_q));
      OP_SDIV_INIT: begin
        dvd_q <= DIV_W'(num_mag) << 17;
        dsr_q <= FIT_W'(den_q);
        rem_q <= '0;
        neg_q <= num_q[FIT_W-1];
        sat_q <= slope_sat;
      end
      OP_BDIV_INIT: begin
        dvd_q <= DIV_W'(b_dvd);
        dsr_q <= FIT_W'(cnt_q) << 8;
        rem_q <= '0;
        neg_q <= numb[63];
      end
      OP_DIV_STEP: begin
        if (div_cnt_q != '0) begin
          rem_q <= q_bit ? rem_sh - dsr_q : rem_sh;
          dvd_q <= dvd_q << 1;
          quo_q <= {quo_q[DIV_W-2:0], q_bit};
        end
      end
      OP_SLOPE_FIN: aq_q <= aq_d;
      OP_B_FIN: bq_q <= bq_d;
      OP_DEV: begin
        slope_q <= aq_q;
        icpt_q  <= bq_q;
        dev_q   <= dev_d;
        degen_q <= 1'b0;
      end
      OP_DEGEN: begin
        slope_q <= '0;
        icpt_q  <= '0;
        dev_q   <= '0;
        degen_q <= 1'b1;
      end
      default: ;
    endcase
  end

  assign stat_o.div_done = (div_cnt_q == '0);
  assign stat_o.degen    = (cnt_q == '0) || den_q[FIT_W-1] || (den_q == '0);

  assign done_o       = done_q;
  assign slope_o      = slope_q;
  assign intercept_o  = icpt_q;
  assign deviation_o  = dev_q;
  assign degenerate_o = degen_q;

endmodule

// ===== hdl/lfd_ctrl.sv =====
module lfd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [1:0]        opcode_i,
  input  lfd_pkg::dp_stat_t stat_i,
  output lfd_pkg::dp_cmd_t  cmd_o,
  output logic              busy_o
);
  import lfd_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:    if (start_i && (opcode_i == OPC_QUERY)) state_d = S_DEN_LO;
      S_DEN_LO:  state_d = S_DEN_HI;
      S_DEN_HI:  state_d = S_DEN_SQ;
      S_DEN_SQ:  state_d = S_NUM_LO;
      S_NUM_LO:  state_d = S_NUM_HI;
      S_NUM_HI:  state_d = S_NUM_SQ;
      S_NUM_SQ:  state_d = S_NUM_END;
      S_NUM_END: state_d = S_CHECK;
      S_CHECK:   state_d = stat_i.degen ? S_IDLE : S_SDIV;
      S_SDIV:    if (stat_i.div_done) state_d = S_SFIN;
      S_SFIN:    state_d = S_BMUL;
      S_BMUL:    state_d = S_BINIT;
      S_BINIT:   state_d = S_BDIV;
      S_BDIV:    if (stat_i.div_done) state_d = S_BFIN;
      S_BFIN:    state_d = S_DMUL;
      S_DMUL:    state_d = S_DEV;
      S_DEV:     state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op = OP_NONE;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          case (opcode_i)
            OPC_ADD:   cmd_o.op = OP_ADD;
            OPC_QUERY: cmd_o.op = OP_CAPTURE;
            OPC_CLEAR: cmd_o.op = OP_CLEAR;
            default:   cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_DEN_LO:  cmd_o.op = OP_M_NXX_LO;
      S_DEN_HI:  cmd_o.op = OP_M_NXX_HI;
      S_DEN_SQ:  cmd_o.op = OP_M_SXSX;
      S_NUM_LO:  cmd_o.op = OP_M_NXY_LO;
      S_NUM_HI:  cmd_o.op = OP_M_NXY_HI;
      S_NUM_SQ:  cmd_o.op = OP_M_SXSY;
      S_NUM_END: cmd_o.op = OP_NUM_END;
      S_CHECK:   cmd_o.op = stat_i.degen ? OP_DEGEN : OP_SDIV_INIT;
      S_SDIV:    cmd_o.op = OP_DIV_STEP;
      S_SFIN:    cmd_o.op = OP_SLOPE_FIN;
      S_BMUL:    cmd_o.op = OP_M_ASX;
      S_BINIT:   cmd_o.op = OP_BDIV_INIT;
      S_BDIV:    cmd_o.op = OP_DIV_STEP;
      S_BFIN:    cmd_o.op = OP_B_FIN;
      S_DMUL:    cmd_o.op = OP_M_AX;
      S_DEV:     cmd_o.op = OP_DEV;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== hdl/line_fit_deviation_top.sv =====
// Add and clear transactions: a new one is accepted every cycle while busy is low.
// A query holds busy until the fit is done or found degenerate; the result
// strobes on done_o in the first cycle with busy low. Two 70-step restoring divisions
// (slope, intercept) run one after the other on one shared divider.
// The receiver cannot stall: done_o is high for one cycle only; the results hold until the next query ends.
// Reset (rst_ni low, asynchronous) clears the count and all running sums.
module line_fit_deviation_top #(
  parameter int unsigned MaxPoints = lfd_pkg::MAX_POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode_i,
  input  logic signed [15:0] x_value_i,
  input  logic signed [15:0] y_value_i,
  output logic               done_o,
  output logic signed [31:0] slope_o,
  output logic signed [31:0] intercept_o,
  output logic        [30:0] deviation_o,
  output logic               degenerate_o
);
  import lfd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lfd_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  lfd_datapath #(
    .MaxPoints (MaxPoints)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .x_value_i    (x_value_i),
    .y_value_i    (y_value_i),
    .done_o       (done_o),
    .slope_o      (slope_o),
    .intercept_o  (intercept_o),
    .deviation_o  (deviation_o),
    .degenerate_o (degenerate_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (opcode_i == OPC_QUERY) |=> busy)
    else $error("query did not start");

  a_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (opcode_i != OPC_QUERY) |=> !done_o)
    else $error("result without query");

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> (slope_o == 0) && (intercept_o == 0) && (deviation_o == 0))
    else $error("degenerate result not zero");

endmodule
